[hdl/r64dec_pkg.sv]
// Package for the radix-64 LSB-first decoder: widths, result type and the
// character-to-symbol map. No dependencies.
package r64dec_pkg;

    localparam int CharW = 8;
    localparam int SymW  = 6;
    localparam int ByteW = 8;

    localparam logic [CharW-1:0] CHAR_DIGIT_0 = 8'h30;  // '0'
    localparam logic [CharW-1:0] CHAR_DIGIT_9 = 8'h39;  // '9'
    localparam logic [CharW-1:0] CHAR_UPPER_A = 8'h41;  // 'A'
    localparam logic [CharW-1:0] CHAR_UPPER_Z = 8'h5A;  // 'Z'
    localparam logic [CharW-1:0] CHAR_LOWER_A = 8'h61;  // 'a'
    localparam logic [CharW-1:0] CHAR_LOWER_Z = 8'h7A;  // 'z'
    localparam logic [CharW-1:0] CHAR_PLUS    = 8'h2B;  // '+'
    localparam logic [CharW-1:0] CHAR_STAR    = 8'h2A;  // '*'

    localparam logic [CharW-1:0] UPPER_BASE = 8'd10;
    localparam logic [CharW-1:0] LOWER_BASE = 8'd36;
    localparam logic [SymW-1:0]  SYM_PLUS   = 6'd62;
    localparam logic [SymW-1:0]  SYM_STAR   = 6'd63;

    typedef struct packed {
        logic             valid;
        logic [SymW-1:0]  value;
    } sym_t;

    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             decode_error;
        logic             message_end;
    } result_t;

    // Map one character to its 6-bit symbol; valid low for anything outside
    // the alphabet.
    function automatic sym_t char_to_sym(input logic [CharW-1:0] c);
        sym_t             s;
        logic [CharW-1:0] diff;
        s.valid = 1'b1;
        s.value = '0;
        diff    = '0;
        if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            diff = c - CHAR_DIGIT_0;
        end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            diff = c - CHAR_UPPER_A + UPPER_BASE;
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            diff = c - CHAR_LOWER_A + LOWER_BASE;
        end else if (c == CHAR_PLUS) begin
            diff = {2'b00, SYM_PLUS};
        end else if (c == CHAR_STAR) begin
            diff = {2'b00, SYM_STAR};
        end else begin
            s.valid = 1'b0;
        end
        s.value = diff[SymW-1:0];
        return s;
    endfunction

endpackage

[hdl/radix64_lsb_first_decoder_top.sv]
// Radix-64 LSB-first streaming decoder, top level.
// Depends on r64dec_pkg (widths, result type, character map).
//
//  Channel | Direction | tdata           | tuser         | tlast
//  --------+-----------+-----------------+---------------+---------------
//  s_      | in        | symbol_char[7:0]| -             | end_of_message
//  m_      | out       | data_byte[7:0]  | decode_error  | message_end
//
// One character per cycle sustained while the result is not stalled; a result
// beat passes from its character through the input register, then the result
// register, before it can be taken.
// The decode of one beat is a table compare and a byte splice between the
// two registers, so a new beat can follow in every cycle.
// Reset (aresetn low, synchronous) empties both registers and clears the
// group position, the previous symbol and the failure flag.
// A stall on m_tready holds the result register; the input register still
// takes one more beat while the result waits, but only if it is empty.
module radix64_lsb_first_decoder_top
    import r64dec_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [CharW-1:0] s_tdata,   // [7:0] symbol_char
    input  logic             s_tlast,   // end_of_message
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [ByteW-1:0] m_tdata,   // [7:0] data_byte
    output logic             m_tuser,   // [0] decode_error
    output logic             m_tlast    // message_end
);

    // Input register
    logic             in_valid_reg;
    logic [CharW-1:0] in_char_reg;
    logic             in_last_reg;

    // Decoder state
    logic [1:0]       grp_pos_reg, grp_pos_next;
    logic [SymW-1:0]  prev_sym_reg, prev_sym_next;
    logic             failed_reg, failed_next;

    // Result register
    logic             out_valid_reg;
    result_t          out_reg, out_next;

    logic             out_free;
    logic             proc_fire;
    logic             emit;
    sym_t             sym;
    logic             fail_now;

    // The result register frees up when empty or when its beat is taken.
    assign out_free  = !out_valid_reg || m_tready;
    assign proc_fire = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;

    assign sym      = char_to_sym(in_char_reg);
    assign fail_now = failed_reg || !sym.valid;

    // Decode one beat: update group state and splice the output byte.
    always_comb begin
        grp_pos_next  = grp_pos_reg;
        prev_sym_next = prev_sym_reg;
        failed_next   = failed_reg;
        emit          = 1'b0;
        out_next      = '0;
        if (fail_now || (grp_pos_reg == 2'd0 && in_last_reg)) begin
            // Swallow the beat; the error result goes out on the last one.
            failed_next = fail_now;
            if (in_last_reg) begin
                emit                  = 1'b1;
                out_next.decode_error = 1'b1;
                out_next.message_end  = 1'b1;
            end
        end else begin
            grp_pos_next  = grp_pos_reg + 2'd1;
            prev_sym_next = sym.value;
            emit          = (grp_pos_reg != 2'd0);
            out_next.message_end = in_last_reg;
            unique case (grp_pos_reg)
                2'd1:    out_next.data_byte = {sym.value[1:0], prev_sym_reg};
                2'd2:    out_next.data_byte = {sym.value[3:0], prev_sym_reg[5:2]};
                2'd3:    out_next.data_byte = {sym.value, prev_sym_reg[5:4]};
                default: out_next.data_byte = '0;
            endcase
        end
        // End of message: return to the reset state.
        if (in_last_reg) begin
            grp_pos_next  = '0;
            prev_sym_next = '0;
            failed_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            grp_pos_reg   <= '0;
            prev_sym_reg  <= '0;
            failed_reg    <= 1'b0;
        end else begin
            // Load the input register whenever it can take a beat.
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (proc_fire) begin
                grp_pos_reg  <= grp_pos_next;
                prev_sym_reg <= prev_sym_next;
                failed_reg   <= failed_next;
            end
            // Advance the result register; hold it while stalled.
            if (out_free) begin
                out_valid_reg <= proc_fire && emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (proc_fire && emit) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.data_byte;
    assign m_tuser  = out_reg.decode_error;
    assign m_tlast  = out_reg.message_end;

`ifndef NO_ASSERTIONS
    // An error beat carries a zero byte and closes the message.
    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0 && m_tlast))
        else $error("error beat without zero byte or message end");

    // After the last character of a message the state is back at reset.
    a_state_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && in_last_reg) |=> (grp_pos_reg == '0 && prev_sym_reg == '0
                                        && !failed_reg))
        else $error("decoder state not cleared at end of message");

    // A failed message produces nothing until its last character.
    a_failed_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && failed_reg && !in_last_reg) |-> !emit)
        else $error("result emitted after failure before message end");
`endif

endmodule
